/* hw/rtl/segment_tree_add_range_max_macros.svh */
// assertion macros for the segment tree block
// used by segment_tree_add_range_max; expects clk and rst_n in scope
`ifndef SEGMENT_TREE_ADD_RANGE_MAX_MACROS_SVH
`define SEGMENT_TREE_ADD_RANGE_MAX_MACROS_SVH

// property checked on every clock edge outside reset
`define STR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define STR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/stree_pkg.sv */
// shared widths, codes and reset values for the segment tree block
// no dependencies
package stree_pkg;
  localparam int PW = 11;   // position and leaf count width
  localparam int DW = 32;   // node value width
  localparam int OW = 31;   // result width
  localparam int DEF_MAX_LEAVES = 1024;
  localparam logic [PW-1:0] LEAF_COUNT_RESET = 11'd1024;
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;
endpackage

/* hw/rtl/stree_if.sv */
// valid/ready channel interfaces for the segment tree block
// depends on stree_pkg
interface stree_in_if import stree_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [PW-1:0]        position;
  logic [PW-1:0]        right_end;
  logic signed [DW-1:0] delta;
  modport source (output valid, func, position, right_end, delta, input ready);
  modport sink (input valid, func, position, right_end, delta, output ready);
endinterface

interface stree_out_if import stree_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [OW-1:0] max_value;
  modport source (output valid, max_value, input ready);
  modport sink (input valid, max_value, output ready);
endinterface

interface stree_cfg_if import stree_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [PW-1:0] leaf_count;
  modport source (output valid, leaf_count, input ready);
  modport sink (input valid, leaf_count, output ready);
endinterface

/* hw/rtl/segment_tree_add_range_max.sv */
// max segment tree with point add and range max query over one node memory
// depends on stree_pkg, stree_if.sv and segment_tree_add_range_max_macros.svh
// Usage:
//   in_chan takes one word per operation: func selects a point add (no result)
//   or a range max query (one word on out_chan). cfg_chan writes leaf_count
//   and is always ready; write it only while the block is idle.
// Operation:
//   One operation at a time; in_chan is ready only in idle.
//   An add in range descends from the root one level at a time until it
//   reaches the leaf, reads and updates the leaf, then writes one node per
//   level back up to the root. An add outside the leaves adds nothing.
//   A query visits the nodes of its range in ST_QWALK, folds in the last
//   node read and then loads the result into the output register.
// Reset:
//   rst_n (synchronous, active low) sets leaf_count to 1024 and starts a
//   clearing pass over all 4*MAX_LEAVES words of the node memory; in_chan
//   stays not ready until it ends.
// Stall:
//   a result sits in the output register until taken; the next add can
//   still run, and a query finishing behind it waits for the register.
`include "segment_tree_add_range_max_macros.svh"

module segment_tree_add_range_max
  import stree_pkg::*;
#(
  parameter int MAX_LEAVES = DEF_MAX_LEAVES
) (
  input  logic         clk,
  input  logic         rst_n,
  stree_in_if.sink     in_chan,
  stree_out_if.source  out_chan,
  stree_cfg_if.sink    cfg_chan
);
  localparam int DEPTH = 4 * MAX_LEAVES;
  localparam int AW    = $clog2(DEPTH);
  localparam int SD    = $clog2(MAX_LEAVES) + 3;
  localparam int SIW   = $clog2(SD);
  localparam int SPW   = $clog2(SD + 1);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DOWN   = 4'd2;
  localparam logic [3:0] ST_LEAF   = 4'd3;
  localparam logic [3:0] ST_UP     = 4'd4;
  localparam logic [3:0] ST_QWALK  = 4'd5;
  localparam logic [3:0] ST_QDONE  = 4'd6;

  typedef struct packed {
    logic [AW-1:0] id;
    logic [PW-1:0] lo;
    logic [PW-1:0] hi;
  } stk_ent_t;

  localparam logic [AW-1:0] ROOT = AW'(1);

  // node memory
  logic [DW-1:0] mem [DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  // control and working registers
  logic [3:0]    st_r, st_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] id_r, id_nxt;
  logic [PW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [PW-1:0] pos_r, pos_nxt, v_r, v_nxt;
  logic [DW-1:0] delta_r, delta_nxt, cur_r, cur_nxt, best_r, best_nxt;
  logic          pend_r, pend_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  stk_ent_t      stk_r [SD];
  logic          stk_we0, stk_we1;
  stk_ent_t      stk_d0, stk_d1;
  logic          out_valid_r, out_valid_nxt;
  logic [OW-1:0] out_data_r, out_data_nxt;
  logic [PW-1:0] leaf_r;

  // effective leaf count
  logic [PW-1:0] n_eff;
  always_comb begin
    if (32'(leaf_r) > 32'(MAX_LEAVES)) n_eff = PW'(MAX_LEAVES);
    else n_eff = leaf_r;
  end

  // split of the current add node
  logic [PW:0]   sum_a;
  logic [PW-1:0] mid_a;
  assign sum_a = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_a = sum_a[PW:1];

  // top of the query stack
  logic [SIW-1:0] top_idx, push_idx;
  stk_ent_t       top;
  logic [PW:0]    sum_t;
  logic [PW-1:0]  mid_t;
  assign top_idx  = SIW'(sp_r - SPW'(1));
  assign push_idx = SIW'(sp_r);
  assign top      = stk_r[top_idx];
  assign sum_t    = {1'b0, top.lo} + {1'b0, top.hi};
  assign mid_t    = sum_t[PW:1];

  logic [DW-1:0] upd_val, up_max, best_cmb;
  assign upd_val  = rdata_r + delta_r;
  assign up_max   = ($signed(cur_r) > $signed(rdata_r)) ? cur_r : rdata_r;
  assign best_cmb = (pend_r && ($signed(rdata_r) > $signed(best_r))) ? rdata_r : best_r;

  logic out_free;
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready      = (st_r == ST_IDLE);
  assign cfg_chan.ready     = 1'b1;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.max_value = out_data_r;

  // next state
  always_comb begin
    st_nxt = st_r;     clr_nxt = clr_r;   id_nxt = id_r;
    lo_nxt = lo_r;     hi_nxt = hi_r;     pos_nxt = pos_r;
    v_nxt = v_r;       delta_nxt = delta_r; cur_nxt = cur_r;
    best_nxt = best_r; pend_nxt = 1'b0;   sp_nxt = sp_r;
    out_valid_nxt = out_valid_r;          out_data_nxt = out_data_r;
    mem_we = 1'b0; mem_waddr = id_r; mem_wdata = '0;
    mem_re = 1'b0; mem_raddr = id_r;
    stk_we0 = 1'b0; stk_we1 = 1'b0; stk_d0 = top; stk_d1 = top;

    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;

    case (st_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_chan.valid) begin
          pos_nxt   = in_chan.position;
          v_nxt     = in_chan.right_end;
          delta_nxt = in_chan.delta;
          id_nxt    = ROOT;
          lo_nxt    = PW'(1);
          hi_nxt    = n_eff;
          best_nxt  = '0;
          if (in_chan.func == FUNC_ADD) begin
            if (n_eff != '0 && in_chan.position != '0 && in_chan.position <= n_eff)
              st_nxt = ST_DOWN;
          end else begin
            if (n_eff != '0 && in_chan.position <= in_chan.right_end) begin
              stk_we1   = 1'b1;
              stk_d1.id = ROOT;
              stk_d1.lo = PW'(1);
              stk_d1.hi = n_eff;
              sp_nxt    = SPW'(1);
              st_nxt    = ST_QWALK;
            end else begin
              st_nxt = ST_QDONE;
            end
          end
        end
      end
      // descend to the leaf, one level per cycle
      ST_DOWN: begin
        if (lo_r == hi_r) begin
          mem_re = 1'b1;
          st_nxt = ST_LEAF;
        end else if (pos_r <= mid_a) begin
          id_nxt = {id_r[AW-2:0], 1'b0};
          hi_nxt = mid_a;
        end else begin
          id_nxt = {id_r[AW-2:0], 1'b1};
          lo_nxt = mid_a + PW'(1);
        end
      end
      // leaf read back: add and write, fetch sibling unless the leaf is the root
      ST_LEAF: begin
        mem_we    = 1'b1;
        mem_wdata = upd_val;
        cur_nxt   = upd_val;
        if (id_r == ROOT) begin
          st_nxt = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = id_r ^ AW'(1);
          st_nxt    = ST_UP;
        end
      end
      // parent gets the max of held child and sibling
      ST_UP: begin
        mem_we    = 1'b1;
        mem_waddr = id_r >> 1;
        mem_wdata = up_max;
        cur_nxt   = up_max;
        id_nxt    = id_r >> 1;
        if ((id_r >> 1) == ROOT) begin
          st_nxt = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = (id_r >> 1) ^ AW'(1);
        end
      end
      // depth-first walk of the query range
      ST_QWALK: begin
        best_nxt = best_cmb;
        if (sp_r == '0) begin
          if (!pend_r) st_nxt = ST_QDONE;
        end else if (top.lo > v_r || top.hi < pos_r) begin
          sp_nxt = sp_r - SPW'(1);
        end else if (pos_r <= top.lo && top.hi <= v_r) begin
          mem_re    = 1'b1;
          mem_raddr = top.id;
          pend_nxt  = 1'b1;
          sp_nxt    = sp_r - SPW'(1);
        end else begin
          stk_we0   = 1'b1;
          stk_d0.id = {top.id[AW-2:0], 1'b1};
          stk_d0.lo = mid_t + PW'(1);
          stk_d0.hi = top.hi;
          stk_we1   = 1'b1;
          stk_d1.id = {top.id[AW-2:0], 1'b0};
          stk_d1.lo = top.lo;
          stk_d1.hi = mid_t;
          sp_nxt    = sp_r + SPW'(1);
        end
      end
      ST_QDONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = best_r[DW-1] ? '0 : best_r[OW-1:0];
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
      leaf_r      <= LEAF_COUNT_RESET;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid) leaf_r <= cfg_chan.leaf_count;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    pos_r      <= pos_nxt;
    v_r        <= v_nxt;
    delta_r    <= delta_nxt;
    cur_r      <= cur_nxt;
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
    if (stk_we0) stk_r[top_idx] <= stk_d0;
    if (stk_we1) stk_r[push_idx] <= stk_d1;
  end

  // checks
  `STR_ASSERT(a_sp_bound, sp_r <= SPW'(SD), "query stack overflow")
  `STR_ASSERT(a_no_accept_busy, !(in_chan.ready && st_r != ST_IDLE), "ready outside idle")
  `STR_ASSERT_NEXT(a_hold_out, out_valid_r && !out_chan.ready, out_valid_r, "result dropped")
  `STR_ASSERT(a_clear_write, !(st_r == ST_CLEAR && !mem_we), "clearing pass skipped a write")
endmodule

/* tb/stree_tb_if.sv */
// channel interfaces for the segment tree testbench
// the testbench instantiates the block's own interfaces from stree_if.sv,
// so nothing of its own is declared here

/* tb/segment_tree_add_range_max_test.sv */
// testbench for segment_tree_add_range_max: random point adds and range max queries
// depends on stree_pkg, stree_if.sv and the block; self-checking against a tree model
module segment_tree_add_range_max_test;
  import stree_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic          func;
    logic [PW-1:0] position;
    logic [PW-1:0] right_end;
    logic [DW-1:0] delta;
  } op_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  stree_in_if  in_chan ();
  stree_out_if out_chan ();
  stree_cfg_if cfg_chan ();

  segment_tree_add_range_max dut (
    .clk(clk), .rst_n(rst_n),
    .in_chan(in_chan.sink), .out_chan(out_chan.source), .cfg_chan(cfg_chan.sink)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tree model state
  logic signed [DW-1:0] tree_node [0:4*DEF_MAX_LEAVES-1];
  int unsigned          model_leaves;
  op_word_t             op_queue [$];
  logic [OW-1:0]        max_queue [$];
  int                   error_count;
  int                   query_count;
  int                   add_count;
  bit                   quiet_phase;
  bit                   stim_done;
  bit                   in_fire;

  function automatic logic signed [DW-1:0] node_at(int unsigned id);
    return id < 4*DEF_MAX_LEAVES ? tree_node[id] : '0;
  endfunction

  function automatic void tree_add(int unsigned id, int unsigned lo, int unsigned hi,
                                   int unsigned pos, logic signed [DW-1:0] amount);
    int unsigned mid;
    logic signed [DW-1:0] a, b;
    if (id >= 4*DEF_MAX_LEAVES) return;
    if (lo == hi) begin
      tree_node[id] = tree_node[id] + amount;
      return;
    end
    mid = (lo + hi) >> 1;
    if (pos <= mid) tree_add(2*id, lo, mid, pos, amount);
    else tree_add(2*id+1, mid+1, hi, pos, amount);
    a = node_at(2*id);
    b = node_at(2*id+1);
    tree_node[id] = a > b ? a : b;
  endfunction

  // nodes outside the range count as zero, as in the block
  function automatic logic signed [DW-1:0] tree_max(int unsigned id, int unsigned lo,
                                                    int unsigned hi, int unsigned u,
                                                    int unsigned v);
    int unsigned mid;
    logic signed [DW-1:0] a, b;
    if (lo > v || hi < u) return '0;
    if (u <= lo && hi <= v) return node_at(id);
    mid = (lo + hi) >> 1;
    a = tree_max(2*id, lo, mid, u, v);
    b = tree_max(2*id+1, mid+1, hi, u, v);
    return a > b ? a : b;
  endfunction

  function automatic void predict_op(op_word_t w);
    int unsigned n;
    logic signed [DW-1:0] best;
    n = model_leaves > DEF_MAX_LEAVES ? DEF_MAX_LEAVES : model_leaves;
    best = '0;
    if (w.func == FUNC_ADD) begin
      if (n != 0 && w.position >= 1 && w.position <= n)
        tree_add(1, 1, n, 32'(w.position), w.delta);
      return;
    end
    if (n != 0 && w.position <= w.right_end)
      best = tree_max(1, 1, n, 32'(w.position), 32'(w.right_end));
    if (best < 0) best = '0;
    max_queue.insert(max_queue.size(), best[OW-1:0]);
  endfunction

  function automatic void queue_op(op_word_t w);
    op_queue.insert(op_queue.size(), w);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // input driver with random idle bursts
  int in_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_gap = 0;
    end else if (in_chan.valid && !in_fire) begin
      // hold word
    end else if (in_gap > 0) begin
      in_gap--;
      in_chan.valid <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      in_gap = $urandom_range(1, 9) - 1;
      in_chan.valid <= 1'b0;
    end else if (op_queue.size() > 0) begin
      op_word_t w;
      w = op_queue.pop_front();
      in_chan.valid     <= 1'b1;
      in_chan.func      <= w.func;
      in_chan.position  <= w.position;
      in_chan.right_end <= w.right_end;
      in_chan.delta     <= w.delta;
    end else begin
      in_chan.valid <= 1'b0;
    end
  end

  // predict on each accepted word
  always @(posedge clk) begin
    in_fire = rst_n && in_chan.valid && in_chan.ready;
    if (in_fire) begin
      op_word_t w;
      w.func = in_chan.func;
      w.position = in_chan.position;
      w.right_end = in_chan.right_end;
      w.delta = in_chan.delta;
      predict_op(w);
      if (w.func == FUNC_QUERY) query_count++;
      else add_count++;
    end
  end

  // result ready with random stall bursts
  int out_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      out_gap = 0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_chan.ready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(1, 9) - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (max_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", out_chan.max_value));
      end else begin
        logic [OW-1:0] want;
        want = max_queue.pop_front();
        if (out_chan.max_value !== want)
          report_mismatch($sformatf("max_value %0d, expected %0d",
                                    out_chan.max_value, want));
      end
    end
  end

  function automatic logic [DW-1:0] rand_delta();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  function automatic logic [PW-1:0] rand_pos(int unsigned n);
    case ($urandom_range(0, 9))
      0: return PW'($urandom_range(0, 2047));
      1: return '0;
      default: return PW'($urandom_range(1, n == 0 ? 1 : n));
    endcase
  endfunction

  function automatic op_word_t make_op(logic f, int p, int r, logic [DW-1:0] d);
    op_word_t w;
    w.func = f;
    w.position = PW'(p);
    w.right_end = PW'(r);
    w.delta = d;
    return w;
  endfunction

  // wait until idle, then let the block finish any add in flight
  task automatic drain();
    while (op_queue.size() > 0 || in_chan.valid || max_queue.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_leaf_count(logic [PW-1:0] n);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.leaf_count <= n;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    model_leaves = 32'(n);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // random phase: mostly adds and queries inside the used leaves
  task automatic random_phase(int count);
    int unsigned n, a, b;
    n = model_leaves > DEF_MAX_LEAVES ? DEF_MAX_LEAVES : model_leaves;
    repeat (count) begin
      if ($urandom_range(0, 1)) begin
        queue_op(make_op(FUNC_ADD, int'(rand_pos(n)), $urandom_range(0, 2047),
                         rand_delta()));
      end else begin
        a = 32'(rand_pos(n));
        b = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : 32'(rand_pos(n));
        if ($urandom_range(0, 4) != 0 && a > b) queue_op(
            make_op(FUNC_QUERY, b, a, $urandom()));
        else queue_op(make_op(FUNC_QUERY, a, b, $urandom()));
      end
    end
    drain();
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.func = FUNC_ADD;
    in_chan.position = '0;
    in_chan.right_end = '0;
    in_chan.delta = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.leaf_count = '0;
    foreach (tree_node[i]) tree_node[i] = '0;
    model_leaves = 32'(LEAF_COUNT_RESET);
    error_count = 0;
    query_count = 0;
    add_count = 0;
    quiet_phase = 1'b0;
    stim_done = 1'b0;
    in_fire = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, wrapping, negatives, empty and outside ranges
    queue_op(make_op(FUNC_QUERY, 1, 1024, 0));
    queue_op(make_op(FUNC_ADD, 1, 0, 32'h7FFF_FFFF));
    queue_op(make_op(FUNC_QUERY, 1, 1024, 0));
    queue_op(make_op(FUNC_ADD, 1, 2047, 1));
    queue_op(make_op(FUNC_QUERY, 1, 1, 0));
    queue_op(make_op(FUNC_ADD, 1024, 0, 32'h0000_0005));
    queue_op(make_op(FUNC_QUERY, 1024, 2047, 0));
    queue_op(make_op(FUNC_QUERY, 1025, 2047, 0));
    queue_op(make_op(FUNC_QUERY, 500, 2, 0));
    queue_op(make_op(FUNC_QUERY, 0, 0, 0));
    queue_op(make_op(FUNC_ADD, 0, 5, 32'd99));
    queue_op(make_op(FUNC_ADD, 2047, 5, 32'd99));
    queue_op(make_op(FUNC_ADD, 1025, 5, 32'd99));
    queue_op(make_op(FUNC_ADD, 700, 0, 32'hFFFF_FFF0));
    queue_op(make_op(FUNC_QUERY, 700, 700, 32'hFFFF_FFFF));
    queue_op(make_op(FUNC_QUERY, 0, 2047, 0));
    queue_op(make_op(FUNC_ADD, 1024, 0, 32'h8000_0000));
    queue_op(make_op(FUNC_QUERY, 2, 1024, 0));
    queue_op(make_op(FUNC_ADD, 1, 0, 32'h8000_0000));
    queue_op(make_op(FUNC_QUERY, 1, 1024, 0));
    drain();

    random_phase(350);
    write_leaf_count(11'd1);
    random_phase(120);
    write_leaf_count(11'd0);
    random_phase(60);
    write_leaf_count(11'd2047);
    random_phase(150);
    write_leaf_count(11'd7);
    random_phase(200);
    write_leaf_count(11'd100);
    random_phase(250);
    quiet_phase = 1'b1;
    write_leaf_count(11'd1024);
    random_phase(250);
    stim_done = 1'b1;

    $display("covered %0d adds and %0d queries over leaf counts 1024, 1, 0, 2047, 7, 100",
             add_count, query_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", error_count);
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end
endmodule
